FILE: hdl/olst_pkg.sv
// Package for the ordered list store: port widths, parameter defaults,
// operation codes and the command record passed to the sequencer.
// No dependencies.
`default_nettype none

package olst_pkg;

  // Parameter defaults
  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Fixed port widths
  localparam int MODE_W  = 3;
  localparam int INDEX_W = 4;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_APPEND     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SWAP       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ_FIRST = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_LAST  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd5;

  // Command fields of one input transaction
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] index_a;
    logic [INDEX_W-1:0] index_b;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/olst_mem.sv
// Element store: one write port and one read port with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module olst_mem #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]         raddr,
  output logic      [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Write on request
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read word every cycle
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/olst_ctrl.sv
// Sequencer for the ordered list store: checks each operation, then walks
// the element store through its single read and write ports. Uses olst_pkg.
`default_nettype none

module olst_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = $clog2(DEPTH),
  parameter int CW         = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire olst_pkg::cmd_t        cmd,
  input  wire logic [DATA_WIDTH-1:0] value_in,
  output logic                       idle,
  output logic                       done,
  input  wire logic                  done_ready,
  output logic      [DATA_WIDTH-1:0] res_data,
  output logic                       res_err,
  output logic      [CW-1:0]         count,
  output logic                       mem_we,
  output logic      [AW-1:0]         mem_waddr,
  output logic      [DATA_WIDTH-1:0] mem_wdata,
  output logic      [AW-1:0]         mem_raddr,
  input  wire logic [DATA_WIDTH-1:0] mem_rdata
);

  import olst_pkg::*;

  localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_EXEC    = 9'b000000010,
    S_SHIFT   = 9'b000000100,
    S_INS     = 9'b000001000,
    S_SWAP_RB = 9'b000010000,
    S_SWAP_WA = 9'b000100000,
    S_SWAP_WB = 9'b001000000,
    S_READ    = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t                state, state_next;
  cmd_t                  cmd_q, cmd_q_next;
  logic [DATA_WIDTH-1:0] val_q, val_q_next;
  logic [CW-1:0]         n, n_next;
  logic [AW-1:0]         ptr, ptr_next;
  logic [DATA_WIDTH-1:0] tmp, tmp_next;
  logic [DATA_WIDTH-1:0] res_data_next;
  logic                  res_err_next;

  logic [XW-1:0] ia_ext, ib_ext, n_ext;
  logic [AW-1:0] ia_addr, ib_addr, n_addr, ptr_dec;
  logic          full, empty, ia_ok, ib_ok;

  // Index checks against the current count
  always_comb begin
    ia_ext  = XW'(cmd_q.index_a);
    ib_ext  = XW'(cmd_q.index_b);
    n_ext   = XW'(n);
    ia_addr = ia_ext[AW-1:0];
    ib_addr = ib_ext[AW-1:0];
    n_addr  = n[AW-1:0];
    ptr_dec = ptr - AW'(1);
    full    = (n == CW'(DEPTH));
    empty   = (n == '0);
    ia_ok   = (ia_ext < n_ext);
    ib_ok   = (ib_ext < n_ext);
  end

  // Sequence one operation
  always_comb begin
    state_next    = state;
    cmd_q_next    = cmd_q;
    val_q_next    = val_q;
    n_next        = n;
    ptr_next      = ptr;
    tmp_next      = tmp;
    res_data_next = res_data;
    res_err_next  = res_err;
    mem_we        = 1'b0;
    mem_waddr     = ptr;
    mem_wdata     = mem_rdata;
    mem_raddr     = ptr_dec;

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_q_next = cmd;
          val_q_next = value_in;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_data_next = '0;
        res_err_next  = 1'b0;
        state_next    = S_DONE;
        case (cmd_q.mode)
          MODE_APPEND: begin
            if (full) begin
              res_err_next = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = n_addr;
              mem_wdata = val_q;
              n_next    = n + CW'(1);
            end
          end
          MODE_REMOVE: begin
            if (empty) begin
              res_err_next = 1'b1;
            end else begin
              n_next = n - CW'(1);
            end
          end
          MODE_SWAP: begin
            if (!ia_ok || !ib_ok) begin
              res_err_next = 1'b1;
            end else begin
              mem_raddr  = ia_addr;
              state_next = S_SWAP_RB;
            end
          end
          MODE_READ_FIRST: begin
            if (empty) begin
              res_err_next = 1'b1;
            end else begin
              mem_raddr  = '0;
              state_next = S_READ;
            end
          end
          MODE_READ_LAST: begin
            if (empty) begin
              res_err_next = 1'b1;
            end else begin
              mem_raddr  = n_addr - AW'(1);
              state_next = S_READ;
            end
          end
          MODE_INSERT: begin
            if (full || !ia_ok) begin
              res_err_next = 1'b1;
            end else begin
              ptr_next   = n_addr;
              mem_raddr  = n_addr - AW'(1);
              state_next = S_SHIFT;
            end
          end
          default: begin
            res_err_next = 1'b1;
          end
        endcase
      end
      // Move one element up a place per cycle, reading the next one down
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = mem_rdata;
        if (ptr_dec == ia_addr) begin
          state_next = S_INS;
        end else begin
          mem_raddr = ptr_dec - AW'(1);
          ptr_next  = ptr_dec;
        end
      end
      S_INS: begin
        mem_we     = 1'b1;
        mem_waddr  = ia_addr;
        mem_wdata  = val_q;
        n_next     = n + CW'(1);
        state_next = S_DONE;
      end
      // Hold the first word, fetch the second
      S_SWAP_RB: begin
        tmp_next   = mem_rdata;
        mem_raddr  = ib_addr;
        state_next = S_SWAP_WA;
      end
      S_SWAP_WA: begin
        mem_we     = 1'b1;
        mem_waddr  = ia_addr;
        mem_wdata  = mem_rdata;
        state_next = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        mem_we     = 1'b1;
        mem_waddr  = ib_addr;
        mem_wdata  = tmp;
        state_next = S_DONE;
      end
      S_READ: begin
        res_data_next = mem_rdata;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (done_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cmd_q    <= cmd_q_next;
    val_q    <= val_q_next;
    ptr      <= ptr_next;
    tmp      <= tmp_next;
    res_data <= res_data_next;
    res_err  <= res_err_next;
  end

  assign idle  = (state == S_IDLE);
  assign done  = (state == S_DONE);
  assign count = n;

endmodule

`default_nettype wire

FILE: hdl/ordered_list_store_top.sv
// Ordered list store, top level: input handshake, sequencer, element store
// and the output result register. Uses olst_pkg, olst_ctrl and olst_mem.
//
// Keeps an ordered list of up to DEPTH words and carries out one operation
// per input transaction: append, remove last, swap, read first, read last,
// or insert before a position. A refused operation sets error, leaves the
// list unchanged and returns zero data; every result carries the count.
// The block takes one transaction at a time through a single-port sequencer
// on the element store, and takes no new one until the sequencer is free
// again. An insert moves its elements up one per cycle through the store's
// read and write ports. A finished result waits in the output register
// while the next transaction is taken.
`default_nettype none

module ordered_list_store_top #(
  parameter int DEPTH      = olst_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = olst_pkg::DATA_WIDTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic        [olst_pkg::MODE_W-1:0]  mode,
  input  wire logic        [olst_pkg::INDEX_W-1:0] index_a,
  input  wire logic        [olst_pkg::INDEX_W-1:0] index_b,
  input  wire logic signed [olst_pkg::VALUE_W-1:0] value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [olst_pkg::VALUE_W-1:0] read_data,
  output logic                                     error,
  output logic             [olst_pkg::COUNT_W-1:0] count
);

  import olst_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t                  cmd;
  logic [DATA_WIDTH-1:0] value_in;
  logic                  start, idle, done, done_ready, res_err;
  logic [DATA_WIDTH-1:0] res_data;
  logic [CW-1:0]         list_count;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  // Accept a transaction whenever the sequencer is free
  assign in_ready    = idle;
  assign start       = in_valid && in_ready;
  assign cmd.mode    = mode;
  assign cmd.index_a = index_a;
  assign cmd.index_b = index_b;
  assign value_in    = DATA_WIDTH'(value);

  // Hand a result over when the output register is empty or draining
  assign done_ready = !out_valid || out_ready;

  olst_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .value_in   (value_in),
    .idle       (idle),
    .done       (done),
    .done_ready (done_ready),
    .res_data   (res_data),
    .res_err    (res_err),
    .count      (list_count),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  olst_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && done_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (done && done_ready) begin
      read_data <= VALUE_W'(res_data);
      error     <= res_err;
      count     <= COUNT_W'(list_count);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/olst_chk.sv
// Port checker for the ordered list store, bound to the top level.
// Uses olst_pkg for port widths.
`default_nettype none

module olst_chk #(
  parameter int DEPTH = olst_pkg::DEPTH_DEFAULT
) (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [olst_pkg::VALUE_W-1:0] read_data,
  input wire logic                                error,
  input wire logic        [olst_pkg::COUNT_W-1:0] count
);

  import olst_pkg::*;

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(error)
      && $stable(count))
    else $error("result changed while stalled");

  // A refused operation returns zero data
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> read_data == '0)
    else $error("refused operation returned data");

  // The count never exceeds the list depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH > 31) || (count <= COUNT_W'(DEPTH)))
    else $error("count beyond depth");

  // Reset leaves the block free and with no result pending
  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind ordered_list_store_top olst_chk #(.DEPTH(DEPTH)) u_olst_chk (.*);

`default_nettype wire
